FILE: hdl/dfs_pkg.sv
// Package for the depth-first search forest unit: payload structs and constants.
// Used by every module under hdl; depends on nothing.
`default_nettype none
package dfs_pkg;
   localparam int NODE_LIMIT = 32;
   localparam logic [5:0] NODE_COUNT_RESET = 6'd32;
   localparam logic [0:0] FUNC_LOAD = 1'b0;
   localparam logic [0:0] FUNC_START = 1'b1;
   localparam logic [0:0] REG_NODE_COUNT = 1'b0;

   typedef struct packed {
      logic [0:0]  func;
      logic [4:0]  row_index;
      logic [31:0] row_bits;
      logic [4:0]  start_node;
   } req_type;

   typedef struct packed {
      logic [4:0] node_id;
      logic [6:0] arrival_time;
      logic [6:0] finish_time;
      logic [4:0] tree_root;
      logic       is_tree_root;
      logic [5:0] tree_node_count;
      logic [5:0] tree_total;
      logic       bad_start;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

FILE: hdl/dfs_forest_timestamps_unit.sv
// Top level of the depth-first search forest unit: APB register, adjacency memory,
// search sequencer, per-node result memory. Depends on dfs_pkg.
`default_nettype none
// The unit takes one beat per start pulse. A load beat (func 0) writes one adjacency
// row. A start beat (func 1) runs a depth-first search with an explicit stack held in
// memory. Every step reads the top of stack (S_TOP), then the adjacency row of that
// node (S_ROW), each as a registered memory read, then pushes the lowest white
// neighbor or pops a finished node (S_STEP). A search of N nodes makes about 2N
// steps. Each tree starts from S_INIT or S_SCAN, and S_SCAN walks the node indices
// for new roots. Results then go out one per node in index order, each through a
// registered memory read in S_OUT before S_OUTW registers it. Each result sits on
// rsp_data with rsp_valid high for exactly one cycle; the receiver cannot stall them.
// busy drops in the cycle that carries the last result, so the next beat can be
// accepted at the edge that ends it.
module dfs_forest_timestamps_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  dfs_pkg::req_type req_data,
   output logic             rsp_valid,
   output dfs_pkg::rsp_type rsp_data,
   input  wire              psel,
   input  wire              penable,
   input  wire              pwrite,
   input  wire [1:0]        paddr,
   input  wire [31:0]       pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import dfs_pkg::*;
   localparam int MAX_NODES = NODE_LIMIT;
   localparam int IW = (MAX_NODES > 32) ? 6 : 5;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_TOP = 8'b00000010, S_ROW = 8'b00000100,
      S_STEP = 8'b00001000, S_SCAN = 8'b00010000, S_OUT = 8'b00100000,
      S_OUTW = 8'b01000000, S_INIT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] ncount_ff;
   logic [6:0] n_ff;
   logic [31:0] adj_mem [MAX_NODES];
   logic [31:0] row_rd_ff;
   logic [4:0] stk_mem [MAX_NODES];
   logic [4:0] stk_rd_ff;
   logic [6:0] sp_ff;
   logic [6:0] time_ff;
   logic [5:0] trees_ff;
   logic [MAX_NODES-1:0] white_ff;
   logic [MAX_NODES-1:0] rflag_ff;
   logic [6:0] arr_mem [MAX_NODES];
   logic [6:0] fin_mem [MAX_NODES];
   logic [4:0] root_mem [MAX_NODES];
   logic [5:0] size_mem [MAX_NODES];
   logic [4:0] cur_root_ff;
   logic [5:0] cur_size_ff;
   logic [6:0] scan_ff;
   logic bad_ff;
   logic [4:0] start_ff;
   logic [6:0] out_ff;

   assign pready = 1'b1;
   assign prdata = {26'd0, ncount_ff};
   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) ncount_ff <= NODE_COUNT_RESET;
      else if (psel && penable && pwrite && paddr == {1'b0, REG_NODE_COUNT})
         ncount_ff <= pwdata[5:0];
   end

   // lowest white neighbor of the top node, masked by node count and diagonal
   logic [MAX_NODES-1:0] cand;
   logic found;
   logic [4:0] nbr;
   always_comb begin
      found = 1'b0;
      nbr = '0;
      for (int j = 0; j < MAX_NODES; j++) begin
         cand[j] = (j < 32) && row_rd_ff[j % 32] && white_ff[j] && (j < n_ff)
                   && (5'(j) != stk_rd_ff);
      end
      for (int j = MAX_NODES - 1; j >= 0; j--) begin
         if (cand[j]) begin
            found = 1'b1;
            nbr = 5'(j);
         end
      end
   end

   logic do_root;
   logic [4:0] root_node;
   logic [6:0] t1;
   logic start_bad;
   assign t1 = time_ff + 7'd1;
   // A start node at or beyond the node count begins no tree of its own.
   assign start_bad = ({2'b0, start_ff} >= n_ff);

   always_comb begin
      state_in = state_ff;
      do_root = 1'b0;
      root_node = scan_ff[4:0];
      case (state_ff)
         S_IDLE: if (start && req_data.func == FUNC_START) state_in = S_INIT;
         S_INIT: begin
            state_in = S_SCAN;
            if (!start_bad) begin
               do_root = 1'b1;
               root_node = start_ff;
               state_in = S_TOP;
            end
         end
         S_SCAN: begin
            if (scan_ff >= n_ff) state_in = S_OUT;
            else if (white_ff[scan_ff[IW-1:0]]) begin
               do_root = 1'b1;
               state_in = S_TOP;
            end
         end
         S_TOP: state_in = S_ROW;
         S_ROW: state_in = S_STEP;
         S_STEP: begin
            if (found && sp_ff < 7'(MAX_NODES)) state_in = S_TOP;
            else if (sp_ff == 7'd1) state_in = S_SCAN;
            else state_in = S_TOP;
         end
         S_OUT: state_in = S_OUTW;
         S_OUTW: state_in = (out_ff + 7'd1 >= n_ff) ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // memories and datapath
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start && req_data.func == FUNC_LOAD)
         adj_mem[req_data.row_index[IW-1:0]] <= req_data.row_bits;
      if (state_ff == S_TOP) stk_rd_ff <= stk_mem[sp_ff[IW-1:0] - 1'b1];
      if (state_ff == S_ROW) row_rd_ff <= adj_mem[stk_rd_ff[IW-1:0]];
      if (do_root) begin
         stk_mem[0] <= root_node;
         arr_mem[root_node[IW-1:0]] <= t1;
         root_mem[root_node[IW-1:0]] <= root_node;
      end
      if (state_ff == S_STEP) begin
         if (found && sp_ff < 7'(MAX_NODES)) begin
            stk_mem[sp_ff[IW-1:0]] <= nbr;
            arr_mem[nbr[IW-1:0]] <= t1;
            root_mem[nbr[IW-1:0]] <= cur_root_ff;
         end else begin
            fin_mem[stk_rd_ff[IW-1:0]] <= t1;
            if (sp_ff == 7'd1) size_mem[cur_root_ff[IW-1:0]] <= cur_size_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0; time_ff <= '0; trees_ff <= '0; out_ff <= '0; scan_ff <= '0;
         white_ff <= '0; rflag_ff <= '0; rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_OUTW);
         if (state_ff == S_IDLE && start && req_data.func == FUNC_START) begin
            n_ff <= (ncount_ff == 6'd0) ? 7'd1 :
                    ({1'b0, ncount_ff} > 7'(MAX_NODES)) ? 7'(MAX_NODES) : {1'b0, ncount_ff};
            start_ff <= req_data.start_node;
            bad_ff <= 1'b0;
            sp_ff <= '0; time_ff <= '0; trees_ff <= '0; out_ff <= '0; scan_ff <= '0;
            white_ff <= '1; rflag_ff <= '0;
         end
         if (state_ff == S_INIT) bad_ff <= start_bad;
         if (do_root) begin
            rflag_ff[root_node[IW-1:0]] <= 1'b1;
            white_ff[root_node[IW-1:0]] <= 1'b0;
            trees_ff <= trees_ff + 6'd1;
            time_ff <= t1;
            sp_ff <= 7'd1;
            cur_root_ff <= root_node;
            cur_size_ff <= 6'd1;
         end else if (state_ff == S_SCAN) scan_ff <= scan_ff + 7'd1;
         if (state_ff == S_STEP) begin
            time_ff <= t1;
            if (found && sp_ff < 7'(MAX_NODES)) begin
               white_ff[nbr[IW-1:0]] <= 1'b0;
               cur_size_ff <= cur_size_ff + 6'd1;
               sp_ff <= sp_ff + 7'd1;
            end else sp_ff <= sp_ff - 7'd1;
         end
         if (state_ff == S_OUTW) begin
            out_ff <= out_ff + 7'd1;
         end
      end
   end

   // registered result read
   logic [6:0] a_rd, f_rd;
   logic [4:0] r_rd;
   logic [5:0] s_rd;
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT) begin
         a_rd <= arr_mem[out_ff[IW-1:0]];
         f_rd <= fin_mem[out_ff[IW-1:0]];
         r_rd <= root_mem[out_ff[IW-1:0]];
         s_rd <= size_mem[out_ff[IW-1:0]];
      end
      if (state_ff == S_OUTW) begin
         rsp_data.node_id <= out_ff[4:0];
         rsp_data.arrival_time <= a_rd;
         rsp_data.finish_time <= f_rd;
         rsp_data.tree_root <= r_rd;
         rsp_data.is_tree_root <= rflag_ff[out_ff[IW-1:0]];
         rsp_data.tree_node_count <= rflag_ff[out_ff[IW-1:0]] ? s_rd : 6'd0;
         rsp_data.tree_total <= trees_ff;
         rsp_data.bad_start <= bad_ff;
         rsp_data.last <= (out_ff + 7'd1 == n_ff);
      end
   end
endmodule
`default_nettype wire

FILE: tb/dfs_forest_timestamps_unit_tb.sv
// Self-checking testbench for the depth-first search forest unit: loads adjacency
// rows, starts searches and compares every per-node result with its own predictor.
// Depends on dfs_pkg and dfs_forest_timestamps_unit.
`timescale 1ns / 1ps
module dfs_forest_timestamps_unit_tb;
   import dfs_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   dfs_forest_timestamps_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Predictor state: our own copy of the adjacency rows and the node count.
   logic [31:0] adj_rows [32];
   logic [5:0]  nodes_in_use = NODE_COUNT_RESET;
   rsp_type     pending_results [$];
   int          error_count = 0;
   longint      cycle_count = 0;

   // The whole forest is computed at once when a start beat is accepted.
   logic [1:0] color [32];
   logic [6:0] t_arr [32];
   logic [6:0] t_fin [32];
   logic [4:0] root_of [32];
   bit         root_flag [32];
   logic [5:0] size_of [32];
   logic [6:0] clock_stamp;
   logic [5:0] forest_trees;

   task automatic grow_from(int r, int n);
      int stk [32];
      int depth;
      int u;
      int nb;
      root_flag[r] = 1;
      forest_trees = forest_trees + 6'd1;
      clock_stamp = clock_stamp + 7'd1;
      t_arr[r] = clock_stamp;
      color[r] = 2'd1;
      root_of[r] = r[4:0];
      size_of[r] = 6'd1;
      depth = 0;
      stk[depth++] = r;
      while (depth > 0) begin
         u = stk[depth - 1];
         nb = n;
         for (int j = 0; j < n; j++)
            if (nb == n && j != u && adj_rows[u][j] && color[j] == 2'd0) nb = j;
         if (nb < n && depth < 32) begin
            clock_stamp = clock_stamp + 7'd1;
            t_arr[nb] = clock_stamp;
            color[nb] = 2'd1;
            root_of[nb] = r[4:0];
            size_of[r] = size_of[r] + 6'd1;
            stk[depth++] = nb;
         end else begin
            clock_stamp = clock_stamp + 7'd1;
            t_fin[u] = clock_stamp;
            color[u] = 2'd2;
            depth--;
         end
      end
   endtask

   task automatic predict_forest(logic [4:0] first_node);
      int n;
      bit bad;
      rsp_type r;
      n = (nodes_in_use == 0) ? 1 : (nodes_in_use > 32 ? 32 : int'(nodes_in_use));
      bad = first_node >= n;
      for (int i = 0; i < 32; i++) begin
         color[i] = 2'd0;
         root_flag[i] = 0;
         size_of[i] = '0;
      end
      clock_stamp = '0;
      forest_trees = '0;
      if (!bad) grow_from(first_node, n);
      for (int i = 0; i < n; i++)
         if (color[i] == 2'd0) grow_from(i, n);
      for (int i = 0; i < n; i++) begin
         r.node_id = i[4:0];
         r.arrival_time = t_arr[i];
         r.finish_time = t_fin[i];
         r.tree_root = root_of[i];
         r.is_tree_root = root_flag[i];
         r.tree_node_count = root_flag[i] ? size_of[i] : 6'd0;
         r.tree_total = forest_trees;
         r.bad_start = bad;
         r.last = (i + 1 == n);
         pending_results.push_back(r);
      end
   endtask

   // Result checker: every strobed beat is matched against the oldest expectation.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type want;
            want = pending_results.pop_front();
            if (want !== rsp_data) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Register write over the APB port: setup cycle, then access cycle.
   task automatic write_node_count(logic [5:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {REG_NODE_COUNT, 1'b0}; pwdata <= {26'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      nodes_in_use = value;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // Send one beat after a random gap unless no_gap is set, and predict what it causes.
   task automatic send_beat(req_type item, bit no_gap = 0);
      int gap;
      logic [63:0] noise;
      gap = no_gap ? 0 : $urandom_range(0, 5);
      repeat (gap) @(negedge clock);
      @(negedge clock);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (item.func == FUNC_LOAD) begin
         adj_rows[item.row_index] = item.row_bits;
      end else begin
         predict_forest(item.start_node);
      end
      @(negedge clock);
      start <= 1'b0;
      noise = {$urandom, $urandom};
      req_data <= noise[$bits(req_type)-1:0];
   endtask

   task automatic load_row(logic [4:0] idx, logic [31:0] bits, bit no_gap = 0);
      req_type item;
      item = '0;
      item.func = FUNC_LOAD;
      item.row_index = idx;
      item.row_bits = bits;
      item.start_node = 5'($urandom);
      send_beat(item, no_gap);
   endtask

   task automatic run_search(logic [4:0] first_node);
      req_type item;
      item.func = FUNC_START;
      item.row_index = 5'($urandom);
      item.row_bits = $urandom;
      item.start_node = first_node;
      send_beat(item);
   endtask

   // Wait until every expected beat is out and the unit has gone quiet.
   task automatic drain;
      int guard;
      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   // Every search must only touch rows already written, so all rows are loaded first.
   task automatic test_directed;
      for (int i = 0; i < 32; i++) load_row(i[4:0], 32'd0, i[0]);
      run_search(5'd0);
      load_row(5'd0, 32'hFFFF_FFFF);      // every edge, diagonal included
      load_row(5'd31, 32'hFFFF_FFFF);
      run_search(5'd31);
      for (int i = 0; i < 31; i++) load_row(i[4:0], 32'h1 << (i + 1));
      run_search(5'd0);                    // one long chain: deepest stack
      run_search(5'd17);
      drain();
   endtask

   task automatic test_node_counts;
      logic [5:0] counts [6] = '{6'd1, 6'd2, 6'd0, 6'd63, 6'd33, 6'd7};
      foreach (counts[k]) begin
         write_node_count(counts[k]);
         run_search(5'd0);
         run_search(5'd31);                // out of range unless the full count
         run_search(5'd6);
         drain();
      end
      write_node_count(6'd32);
   endtask

   // Random graphs, half of the rows sparse and a quarter dense, under various counts.
   task automatic test_random_graphs;
      logic [5:0] n;
      logic [31:0] bits;
      for (int phase = 0; phase < 11; phase++) begin
         n = (phase % 4 == 3) ? 6'd32 : 6'($urandom_range(1, 12));
         if (phase == 5) n = 6'($urandom_range(33, 63));
         write_node_count(n);
         for (int s = 0; s < 3; s++) begin
            for (int r = 0; r < 6; r++) begin
               case ($urandom_range(0, 3))
                  0: bits = $urandom;
                  1: bits = $urandom & $urandom & $urandom;
                  2: bits = 32'h1 << $urandom_range(0, 31);
                  default: bits = ~($urandom & $urandom);
               endcase
               load_row(5'($urandom), bits);
            end
            run_search($urandom_range(0, 2) == 0 ? 5'($urandom) : 5'($urandom_range(0, 11)));
         end
         drain();
      end
   endtask

   initial begin
      for (int i = 0; i < 32; i++) begin
         adj_rows[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_node_counts();
      test_random_graphs();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
